### hw/rtl/tfp_pkg.sv
package tfp_pkg;

	localparam int SEC_BITS     = 32;
	localparam int IDX_BITS     = 28;
	localparam int RATE_BITS    = 8;
	localparam int COUNT_BITS   = 11;
	localparam int KIND_BITS    = 3;
	// sample index after the half-frame shift
	localparam int IDX_ADJ_BITS = IDX_BITS + 1;

	localparam int IN_FIELD_BITS = SEC_BITS + IDX_BITS + RATE_BITS + COUNT_BITS;
	localparam int IN_DATA_BITS  = ((IN_FIELD_BITS + 7) / 8) * 8;
	localparam int IN_USER_BITS  = 2;

	localparam int MUL_A_BITS = 32;
	localparam int MUL_B_BITS = 20;
	localparam int MUL_P_BITS = MUL_A_BITS + MUL_B_BITS;
	localparam int PROD1_BITS = SEC_BITS + RATE_BITS;
	localparam int HI_BITS    = PROD1_BITS - MUL_A_BITS;

	localparam logic [RATE_BITS-1:0]  HALF_RATE_MHZ = RATE_BITS'(200);
	localparam logic [MUL_B_BITS-1:0] HZ_PER_MHZ    = MUL_B_BITS'(1000000);

	localparam int FRAME_SAMPLES_DEF = 1024;
	localparam int POSITION_BITS_DEF = 48;

	typedef enum logic [KIND_BITS-1:0] {
		KIND_WRITE  = 3'd0,
		KIND_NEW    = 3'd1,
		KIND_EXTEND = 3'd2,
		KIND_ORDER  = 3'd3,
		KIND_RANGE  = 3'd4
	} tfp_kind_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ORDER,
		ST_MUL1,
		ST_MUL2,
		ST_MUL3,
		ST_MUL4,
		ST_IDX1,
		ST_IDX2,
		ST_RANGE,
		ST_CHECK,
		ST_GAP,
		ST_FRAME,
		ST_WRITE
	} tfp_state_t;

	typedef struct packed {
		logic sub;
		logic sat;
	} tfp_alu_ctl_t;

endpackage

### hw/rtl/tfp_mul.sv
module tfp_mul import tfp_pkg::*; (
	input  logic                  clk,
	input  logic                  en,
	input  logic [MUL_A_BITS-1:0] a,
	input  logic [MUL_B_BITS-1:0] b,
	output logic [MUL_P_BITS-1:0] p
);

	logic [MUL_P_BITS-1:0] p_q;

	always_ff @(posedge clk) begin
		if (en) begin
			p_q <= MUL_P_BITS'(a) * MUL_P_BITS'(b);
		end
	end

	assign p = p_q;

endmodule

### hw/rtl/tfp_alu.sv
module tfp_alu import tfp_pkg::*; #(
	parameter int AW = 62,
	parameter int PW = POSITION_BITS_DEF
) (
	input  tfp_alu_ctl_t   ctl,
	input  logic signed [AW-1:0] a,
	input  logic signed [AW-1:0] b,
	output logic signed [AW-1:0] y
);

	localparam logic [AW-1:0] POS_MAX = {{(AW-PW){1'b0}}, {PW{1'b1}}};

	logic signed [AW-1:0] sum;
	logic                 over;

	always_comb begin
		sum  = ctl.sub ? (a - b) : (a + b);
		over = !sum[AW-1] && (|sum[AW-2:PW]);
		// clamp at the top of the position space
		y    = (ctl.sat && over) ? $signed(POS_MAX) : sum;
	end

endmodule

### hw/rtl/transient_frame_placer_with_loss_flags_top.sv
// Channel  Dir  Beat                     tdata / tuser / tlast
// s_*      in   one frame header         tdata: second_stamp, sample_index, rate_mhz,
//                                        sample_count; tuser: checksum_ok, all_zero
// m_*      out  one placement result     tdata: kind, position, length; tlast: last
//
// For each header, the offset goes through one shared 32x20 multiplier three times and one
// shared adder in sequence. Out-of-order headers are dropped at the order check, out-of-range
// ones at the range check, before any flag or write result.
// s_tready is high only while the sequencer is idle; a stalled m_tready holds the
// sequencer in its emitting step. Reset clears origin, written end and flag range.
module transient_frame_placer_with_loss_flags_top import tfp_pkg::*; #(
	parameter int FRAME_SAMPLES = FRAME_SAMPLES_DEF,
	parameter int POSITION_BITS = POSITION_BITS_DEF,
	localparam int OUT_FIELD_BITS = KIND_BITS + 2 * POSITION_BITS,
	localparam int OUT_DATA_BITS  = ((OUT_FIELD_BITS + 7) / 8) * 8
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     s_tvalid,
	output logic                     s_tready,
	// second_stamp, sample_index, rate_mhz, sample_count
	input  logic [IN_DATA_BITS-1:0]  s_tdata,
	// checksum_ok, all_zero
	input  logic [IN_USER_BITS-1:0]  s_tuser,
	output logic                     m_tvalid,
	input  logic                     m_tready,
	// kind, position, length
	output logic [OUT_DATA_BITS-1:0] m_tdata,
	output logic                     m_tlast
);

	localparam int PW = POSITION_BITS;
	localparam int AW = ((PW > 60) ? PW : 60) + 2;
	localparam logic [IDX_ADJ_BITS-1:0] HALF_FRAME = IDX_ADJ_BITS'(FRAME_SAMPLES / 2);

	// input unpacking
	logic [SEC_BITS-1:0]     in_sec;
	logic [IDX_BITS-1:0]     in_idx;
	logic [RATE_BITS-1:0]    in_rate;
	logic [COUNT_BITS-1:0]   in_count;
	logic [IDX_ADJ_BITS-1:0] in_idx_adj;

	assign in_sec   = s_tdata[SEC_BITS-1:0];
	assign in_idx   = s_tdata[SEC_BITS+IDX_BITS-1:SEC_BITS];
	assign in_rate  = s_tdata[SEC_BITS+IDX_BITS+RATE_BITS-1:SEC_BITS+IDX_BITS];
	assign in_count = s_tdata[IN_FIELD_BITS-1:SEC_BITS+IDX_BITS+RATE_BITS];
	assign in_idx_adj = IDX_ADJ_BITS'(in_idx)
		+ (((in_rate == HALF_RATE_MHZ) && in_sec[0]) ? HALF_FRAME : '0);

	tfp_state_t state_q, state_d;

	logic [SEC_BITS-1:0]     sec_q;
	logic [IDX_ADJ_BITS-1:0] idx_q;
	logic [RATE_BITS-1:0]    rate_q;
	logic [COUNT_BITS-1:0]   count_q;
	logic                    flag_q;
	logic                    org_valid_q;
	logic [SEC_BITS-1:0]     org_sec_q;
	logic [IDX_ADJ_BITS-1:0] org_idx_q;
	logic [PW-1:0]           written_end_q;
	logic                    range_exists_q;
	logic [PW-1:0]           range_end_q;
	logic signed [AW-1:0]    acc_q;
	logic signed [AW-1:0]    off_q;
	logic [PW-1:0]           frame_end_q;
	logic [HI_BITS-1:0]      hi_q;

	logic                    out_valid_q;
	tfp_kind_t               out_kind_q;
	logic [PW-1:0]           out_pos_q;
	logic [PW-1:0]           out_len_q;
	logic                    out_last_q;

	// shared units
	tfp_alu_ctl_t          alu_ctl;
	logic signed [AW-1:0]  alu_a, alu_b, alu_y;
	logic                  mul_en;
	logic [MUL_A_BITS-1:0] mul_a;
	logic [MUL_B_BITS-1:0] mul_b;
	logic [MUL_P_BITS-1:0] mul_p;

	tfp_alu #(.AW(AW), .PW(PW)) u_alu (
		.ctl (alu_ctl),
		.a   (alu_a),
		.b   (alu_b),
		.y   (alu_y)
	);

	tfp_mul u_mul (
		.clk (clk),
		.en  (mul_en),
		.a   (mul_a),
		.b   (mul_b),
		.p   (mul_p)
	);

	// sequencer controls
	logic      accept;
	logic      emit_ok;
	logic      emit;
	tfp_kind_t emit_kind;
	logic [PW-1:0] emit_pos;
	logic [PW-1:0] emit_len;
	logic      emit_last;
	logic      acc_ld, off_ld, fe_ld, hi_ld, we_ld, rng_ld;
	logic      order_bad, range_bad, gap_pos, open_new;

	assign accept  = s_tvalid && s_tready;
	assign emit_ok = !out_valid_q || m_tready;

	assign order_bad = (sec_q < org_sec_q) || ((sec_q == org_sec_q) && (idx_q < org_idx_q));
	assign range_bad = off_q[AW-1] || (|acc_q[AW-2:PW]);
	assign gap_pos   = !acc_q[AW-1] && (|acc_q);

	always_comb begin
		state_d   = state_q;
		s_tready  = 1'b0;
		alu_ctl   = '0;
		alu_a     = acc_q;
		alu_b     = '0;
		mul_en    = 1'b0;
		mul_a     = mul_p[MUL_A_BITS-1:0];
		mul_b     = HZ_PER_MHZ;
		emit      = 1'b0;
		emit_kind = KIND_WRITE;
		emit_pos  = '0;
		emit_len  = '0;
		emit_last = 1'b0;
		acc_ld    = 1'b0;
		off_ld    = 1'b0;
		fe_ld     = 1'b0;
		hi_ld     = 1'b0;
		we_ld     = 1'b0;
		rng_ld    = 1'b0;
		open_new  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					state_d = ST_ORDER;
				end
			end
			ST_ORDER: begin
				alu_ctl.sub = 1'b1;
				alu_a       = AW'(sec_q);
				alu_b       = AW'(org_sec_q);
				if (order_bad) begin
					if (emit_ok) begin
						emit      = 1'b1;
						emit_kind = KIND_ORDER;
						emit_last = 1'b1;
						state_d   = ST_IDLE;
					end
				end else begin
					acc_ld  = 1'b1;
					state_d = ST_MUL1;
				end
			end
			ST_MUL1: begin
				mul_en  = 1'b1;
				mul_a   = acc_q[MUL_A_BITS-1:0];
				mul_b   = MUL_B_BITS'(rate_q);
				state_d = ST_MUL2;
			end
			ST_MUL2: begin
				// low 32 bits of seconds*rate times 10^6; keep the top byte
				mul_en  = 1'b1;
				hi_ld   = 1'b1;
				state_d = ST_MUL3;
			end
			ST_MUL3: begin
				alu_a   = AW'(mul_p);
				acc_ld  = 1'b1;
				mul_en  = 1'b1;
				mul_a   = MUL_A_BITS'(hi_q);
				state_d = ST_MUL4;
			end
			ST_MUL4: begin
				alu_b   = AW'(mul_p) << MUL_A_BITS;
				acc_ld  = 1'b1;
				state_d = ST_IDX1;
			end
			ST_IDX1: begin
				alu_b   = AW'(idx_q);
				acc_ld  = 1'b1;
				state_d = ST_IDX2;
			end
			ST_IDX2: begin
				alu_ctl.sub = 1'b1;
				alu_b       = AW'(org_idx_q);
				acc_ld      = 1'b1;
				state_d     = ST_RANGE;
			end
			ST_RANGE: begin
				off_ld  = 1'b1;
				alu_b   = AW'(count_q);
				acc_ld  = 1'b1;
				state_d = ST_CHECK;
			end
			ST_CHECK: begin
				if (range_bad) begin
					if (emit_ok) begin
						emit      = 1'b1;
						emit_kind = KIND_RANGE;
						emit_last = 1'b1;
						state_d   = ST_IDLE;
					end
				end else begin
					// acc holds the frame end; turn it into the gap
					fe_ld       = 1'b1;
					alu_ctl.sub = 1'b1;
					alu_a       = off_q;
					alu_b       = AW'(written_end_q);
					acc_ld      = 1'b1;
					state_d     = ST_GAP;
				end
			end
			ST_GAP: begin
				if (gap_pos) begin
					open_new    = !range_exists_q || (written_end_q > range_end_q);
					alu_ctl.sat = 1'b1;
					alu_a       = open_new ? AW'(written_end_q) : AW'(range_end_q);
					alu_b       = acc_q;
					if (emit_ok) begin
						emit      = 1'b1;
						emit_kind = open_new ? KIND_NEW : KIND_EXTEND;
						emit_pos  = open_new ? written_end_q : '0;
						emit_len  = acc_q[PW-1:0];
						rng_ld    = 1'b1;
						state_d   = ST_FRAME;
					end
				end else begin
					state_d = ST_FRAME;
				end
			end
			ST_FRAME: begin
				if (flag_q) begin
					open_new    = !range_exists_q || (off_q[PW-1:0] > range_end_q);
					alu_ctl.sat = 1'b1;
					alu_a       = open_new ? off_q : AW'(range_end_q);
					alu_b       = AW'(count_q);
					if (emit_ok) begin
						emit      = 1'b1;
						emit_kind = open_new ? KIND_NEW : KIND_EXTEND;
						emit_pos  = open_new ? off_q[PW-1:0] : '0;
						emit_len  = PW'(count_q);
						rng_ld    = 1'b1;
						state_d   = ST_WRITE;
					end
				end else begin
					state_d = ST_WRITE;
				end
			end
			ST_WRITE: begin
				if (emit_ok) begin
					emit      = 1'b1;
					emit_kind = KIND_WRITE;
					emit_pos  = off_q[PW-1:0];
					emit_len  = PW'(count_q);
					emit_last = 1'b1;
					we_ld     = 1'b1;
					state_d   = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// architectural state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			org_valid_q    <= 1'b0;
			org_sec_q      <= '0;
			org_idx_q      <= '0;
			written_end_q  <= '0;
			range_exists_q <= 1'b0;
			range_end_q    <= '0;
		end else begin
			if (accept && !org_valid_q) begin
				org_valid_q   <= 1'b1;
				org_sec_q     <= in_sec;
				org_idx_q     <= in_idx_adj;
				written_end_q <= '0;
			end else if (we_ld) begin
				written_end_q <= frame_end_q;
			end
			if (rng_ld) begin
				range_exists_q <= 1'b1;
				range_end_q    <= alu_y[PW-1:0];
			end
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		if (accept) begin
			sec_q   <= in_sec;
			idx_q   <= in_idx_adj;
			rate_q  <= in_rate;
			count_q <= in_count;
			flag_q  <= (in_count != '0) && (!s_tuser[0] || s_tuser[1]);
		end
		if (acc_ld) begin
			acc_q <= alu_y;
		end
		if (off_ld) begin
			off_q <= acc_q;
		end
		if (fe_ld) begin
			frame_end_q <= acc_q[PW-1:0];
		end
		if (hi_ld) begin
			hi_q <= mul_p[PROD1_BITS-1:MUL_A_BITS];
		end
	end

	// output word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_kind_q <= emit_kind;
			out_pos_q  <= emit_pos;
			out_len_q  <= emit_len;
			out_last_q <= emit_last;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tlast  = out_last_q;
	assign m_tdata  = {{(OUT_DATA_BITS-OUT_FIELD_BITS){1'b0}}, out_len_q, out_pos_q, out_kind_q};

`ifndef SYNTHESIS
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("header accepted while previous one still in work");

	a_flag_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (out_kind_q == KIND_NEW || out_kind_q == KIND_EXTEND) |-> !m_tlast)
		else $error("flag word marked as last of its frame");

	a_drop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (out_kind_q == KIND_ORDER || out_kind_q == KIND_RANGE)
		|-> out_pos_q == '0 && out_len_q == '0 && m_tlast)
		else $error("drop word carries payload or is not last");

	a_extend_no_pos: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && out_kind_q == KIND_EXTEND |-> out_pos_q == '0)
		else $error("extension word carries a position");
`endif

endmodule
